// ===== rtl/bspm_pkg.sv =====
package bspm_pkg;

  // Stream and configuration port widths.
  localparam int IN_W      = 72;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_SPEED       = 3'd0,
    CFG_KI_SPEED       = 3'd1,
    CFG_SPEED_TARGET   = 3'd2,
    CFG_POSITION_LIMIT = 3'd3,
    CFG_PITCH_LIMIT    = 3'd4,
    CFG_ROLL_LIMIT     = 3'd5
  } cfg_idx_e;

  localparam logic [12:0] POSITION_LIMIT_RST = 13'd3550;
  localparam logic [6:0]  PITCH_LIMIT_RST    = 7'd30;
  localparam logic [6:0]  ROLL_LIMIT_RST     = 7'd10;

  // Command from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

endpackage

// ===== rtl/bspm_mac.sv =====
module bspm_mac #(
  parameter int AW    = 25,
  parameter int MW    = 16,
  parameter int ACC_W = 43
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bspm_pkg::mac_cmd_t      cmd_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [MW-1:0]    b_i,
  input  logic signed [ACC_W-1:0] init_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);
  import bspm_pkg::*;

  localparam int CNT_W = $clog2(MW);

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] a_q;
  logic signed [ACC_W-1:0] acc_d;
  logic [MW-1:0]           b_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q;
  logic                    done_q;
  logic                    last_bit;

  // The multiplier bits are consumed from the least significant end; the
  // final bit is the sign bit of a two's complement operand, so it subtracts.
  assign last_bit = (cnt_q == '0);
  assign acc_d    = last_bit ? (acc_q - a_q) : (acc_q + a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_bit;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= ACC_W'(a_i);
      b_q <= b_i;
      if (cmd_i.clear) begin
        acc_q <= init_i;
      end
    end else if (busy_q) begin
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
      if (b_q[0]) begin
        acc_q <= acc_d;
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== rtl/balance_speed_pi_motor_drive.sv =====
// Speed PI loop and motor drive for a two-wheeled balancing robot.
// Input channel (s_axis): one item per control tick. tuser carries the command
// bit; a command of one runs the speed update before the motor update, a
// command of zero only forms the motor drive from the stored speed loop output.
// Output channel (m_axis): one item per accepted input item, holding the
// direction and duty for both motors, the tilt stop flag and the speed output.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; write only while no item is in flight.
// Sequence: a speed update runs four products through one shift-and-add
// multiplier that takes one multiplier bit per cycle, MW = max(16, FRAC_BITS+2)
// bits, in the order speed filter, position update, PI loop, motor drive. An
// item with command zero goes straight to the motor drive. One item is worked
// on at a time; s_axis_tready is high only while the block waits for an item.
// The result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds the block only when a second result is ready.
// Reset clears the speed filter, the position and the speed loop output, and
// returns the limits and gains to their reset values.
module balance_speed_pi_motor_drive #(
  parameter int FRAC_BITS = 8,
  parameter int DUTY_MAX  = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pulse_left[9:0], pulse_right[19:10], pitch_angle[35:20], roll_angle[51:36],
  // angle_output[68:52], zero fill up to bit 71
  input  logic [bspm_pkg::IN_W-1:0]         s_axis_tdata,
  // command[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_reverse[0], left_duty[8:1], right_reverse[9], right_duty[17:10],
  // tilt_stop[18], speed_output[42:19], zero fill up to bit 47
  output logic [bspm_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [bspm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bspm_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import bspm_pkg::*;

  localparam int AW     = (FRAC_BITS + 12 > 25) ? FRAC_BITS + 12 : 25;
  localparam int MW     = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int ACC_W  = AW + MW + 2;
  localparam int CL_W   = ((FRAC_BITS + 14 > 25) ? FRAC_BITS + 14 : 25) + 1;
  localparam int CMP_W  = (FRAC_BITS + 8 > 17) ? FRAC_BITS + 8 : 17;
  localparam int SUM_W  = 26;
  localparam int C7     = (7 * (2 ** FRAC_BITS) + 5) / 10;
  localparam int C3     = (2 ** FRAC_BITS) - C7;

  localparam logic signed [MW-1:0]    C7_B    = MW'(C7);
  localparam logic signed [MW-1:0]    C3_B    = MW'(C3);
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [23:0]      S24_MAX = 24'h7FFFFF;
  localparam logic signed [23:0]      S24_MIN = 24'h800000;
  localparam logic signed [21:0]      S22_MAX = 22'h1FFFFF;
  localparam logic signed [21:0]      S22_MIN = 22'h200000;
  localparam logic [SUM_W-1:0]        DUTY_LIM = SUM_W'(DUTY_MAX);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_FS1  = 8'b0000_0010,
    ST_FS2  = 8'b0000_0100,
    ST_POS  = 8'b0000_1000,
    ST_PIGO = 8'b0001_0000,
    ST_PI1  = 8'b0010_0000,
    ST_PI2  = 8'b0100_0000,
    ST_DRV  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] kp_q, ki_q;
  logic signed [10:0] tgt_q;
  logic [12:0]        plim_q;
  logic [6:0]         pitch_lim_q, roll_lim_q;

  logic signed [23:0] fs_q, fs_d;
  logic signed [21:0] ps_q, ps_d;
  logic signed [23:0] slo_q, slo_d;

  logic signed [9:0]  pl_q, pr_q;
  logic signed [15:0] pitch_q, roll_q;
  logic signed [16:0] ao_q;
  logic               capture;

  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q, out_d;
  logic               load_out;
  logic               out_free;

  mac_cmd_t                mac_cmd;
  logic signed [AW-1:0]    mac_a;
  logic signed [MW-1:0]    mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_done;

  logic signed [10:0]      pulse_sum;
  logic signed [AW-1:0]    tgt_a, pulse_a, fs_a, ps_a;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [23:0]      acc_sat24;
  logic signed [CL_W-1:0]  pos_sum, lim_p, lim_n, pos_cl;
  logic signed [21:0]      pos_sat22;

  logic signed [SUM_W-1:0] drv_sum;
  logic                    drv_neg;
  logic [SUM_W-1:0]        drv_abs, drv_mag, drv_cl;
  logic signed [CMP_W-1:0] pitch_w, roll_w, pitch_lim_w, roll_lim_w;
  logic                    stop;
  logic                    rev;
  logic [7:0]              duty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      tgt_q       <= '0;
      plim_q      <= POSITION_LIMIT_RST;
      pitch_lim_q <= PITCH_LIMIT_RST;
      roll_lim_q  <= ROLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KP_SPEED:       kp_q        <= cfg_wdata_i;
        CFG_KI_SPEED:       ki_q        <= cfg_wdata_i;
        CFG_SPEED_TARGET:   tgt_q       <= cfg_wdata_i[10:0];
        CFG_POSITION_LIMIT: plim_q      <= cfg_wdata_i[12:0];
        CFG_PITCH_LIMIT:    pitch_lim_q <= cfg_wdata_i[6:0];
        CFG_ROLL_LIMIT:     roll_lim_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign capture       = s_axis_tready && s_axis_tvalid;

  always_ff @(posedge clk_i) begin
    if (capture) begin
      pl_q    <= s_axis_tdata[9:0];
      pr_q    <= s_axis_tdata[19:10];
      pitch_q <= s_axis_tdata[35:20];
      roll_q  <= s_axis_tdata[51:36];
      ao_q    <= s_axis_tdata[68:52];
    end
  end

  // Operands for the shared multiplier, all in Q.F.
  assign pulse_sum = 11'(pl_q) + 11'(pr_q);
  assign pulse_a   = AW'(pulse_sum) <<< FRAC_BITS;
  assign tgt_a     = AW'(tgt_q) <<< FRAC_BITS;
  assign fs_a      = AW'(fs_q);
  assign ps_a      = AW'(ps_q);

  // Floor shift of the accumulator and saturation to 24 bits.
  assign acc_sh    = mac_acc >>> FRAC_BITS;
  assign acc_sat24 = ((&acc_sh[ACC_W-1:23]) || !(|acc_sh[ACC_W-1:23])) ? acc_sh[23:0]
                   : (acc_sh[ACC_W-1] ? S24_MIN : S24_MAX);

  // Position clamp to the configured limit, then saturation to 22 bits.
  assign pos_sum   = CL_W'(ps_q) + CL_W'(fs_q);
  assign lim_p     = CL_W'({plim_q, {FRAC_BITS{1'b0}}});
  assign lim_n     = -lim_p;
  assign pos_cl    = (pos_sum > lim_p) ? lim_p : ((pos_sum < lim_n) ? lim_n : pos_sum);
  assign pos_sat22 = ((&pos_cl[CL_W-1:21]) || !(|pos_cl[CL_W-1:21])) ? pos_cl[21:0]
                   : (pos_cl[CL_W-1] ? S22_MIN : S22_MAX);

  // Motor drive: truncation toward zero is a shift of the magnitude.
  assign drv_sum = -SUM_W'(ao_q) - SUM_W'(slo_q);
  assign drv_neg = drv_sum[SUM_W-1];
  assign drv_abs = drv_neg ? SUM_W'(-drv_sum) : SUM_W'(drv_sum);
  assign drv_mag = drv_abs >> FRAC_BITS;
  assign drv_cl  = (drv_mag > DUTY_LIM) ? DUTY_LIM : drv_mag;

  assign pitch_w     = CMP_W'(pitch_q);
  assign roll_w      = CMP_W'(roll_q);
  assign pitch_lim_w = CMP_W'({pitch_lim_q, {FRAC_BITS{1'b0}}});
  assign roll_lim_w  = CMP_W'({roll_lim_q, {FRAC_BITS{1'b0}}});
  assign stop = (pitch_w > pitch_lim_w) || (pitch_w < -pitch_lim_w)
             || (roll_w > roll_lim_w) || (roll_w < -roll_lim_w);

  assign rev  = !stop && drv_neg && (drv_cl != '0);
  assign duty = stop ? 8'd0 : drv_cl[7:0];
  assign out_d = {5'b0, slo_q, stop, duty, rev, duty, rev};

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    mac_cmd  = '0;
    mac_a    = fs_a;
    mac_b    = C7_B;
    fs_d     = fs_q;
    ps_d     = ps_q;
    slo_d    = slo_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0]) begin
            mac_cmd.start = 1'b1;
            mac_cmd.clear = 1'b1;
            state_d       = ST_FS1;
          end else begin
            state_d = ST_DRV;
          end
        end
      end
      ST_FS1: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_a         = pulse_a;
          mac_b         = C3_B;
          state_d       = ST_FS2;
        end
      end
      ST_FS2: begin
        if (mac_done) begin
          fs_d    = acc_sat24;
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        ps_d    = pos_sat22;
        state_d = ST_PIGO;
      end
      ST_PIGO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_a         = tgt_a - ps_a;
        mac_b         = MW'(ki_q);
        state_d       = ST_PI1;
      end
      ST_PI1: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_a         = tgt_a - fs_a;
          mac_b         = MW'(kp_q);
          state_d       = ST_PI2;
        end
      end
      ST_PI2: begin
        if (mac_done) begin
          slo_d   = acc_sat24;
          state_d = ST_DRV;
        end
      end
      ST_DRV: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fs_q      <= '0;
      ps_q      <= '0;
      slo_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fs_q    <= fs_d;
      ps_q    <= ps_d;
      slo_q   <= slo_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  bspm_mac #(
    .AW    (AW),
    .MW    (MW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .init_i (HALF),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

endmodule

// ===== rtl/bspm_checker.sv =====
module bspm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [bspm_pkg::OUT_W-1:0] m_axis_tdata
);
  import bspm_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Both motors always receive the same drive.
  a_motor_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[9])
                   && (m_axis_tdata[8:1] == m_axis_tdata[17:10]))
    else $error("left and right drive differ");

  // A tilt stop leaves no drive at all.
  a_tilt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18] |-> (m_axis_tdata[8:0] == 9'd0))
    else $error("drive present during tilt stop");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

endmodule

bind balance_speed_pi_motor_drive bspm_checker u_bspm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
